@@ src/fixed_point_double_converter_assert.svh @@
`ifndef FIXED_POINT_DOUBLE_CONVERTER_ASSERT_SVH
`define FIXED_POINT_DOUBLE_CONVERTER_ASSERT_SVH
// assertion helpers
`define FPDC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FPDC_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`endif

@@ src/fpdc_pkg.sv @@
package fpdc_pkg;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 6;
    localparam logic [CfgIdxW-1:0] REG_TOTAL_WIDTH = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_INT_BITS = 1'b1;
    localparam logic FUNC_FIX2DBL = 1'b0;
    localparam logic FUNC_DBL2FIX = 1'b1;
    localparam logic [31:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FIX_MIN = 32'h8000_0000;

    typedef struct packed {
        logic        func;
        logic [31:0] fixed_in;
        logic [63:0] double_in;
    } req_t;

    typedef struct packed {
        logic [63:0] double_out;
        logic [31:0] fixed_out;
        logic        saturated;
    } rsp_t;

    // stage 1 -> stage 2
    typedef struct packed {
        logic        func;
        // fixed to double
        logic        sign;
        logic [31:0] mag;
        logic [5:0]  frac;
        // double to fixed
        logic        zero_out;
        logic        sat;
        logic [31:0] sat_val;
        logic [52:0] mant;
        logic [6:0]  rsh;
        logic        dsign;
    } s1_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic        func;
        logic        sign;
        logic [31:0] norm;
        logic [5:0]  lz;
        logic        mzero;
        logic [5:0]  frac;
        logic        zero_out;
        logic        sat;
        logic [31:0] sat_val;
        logic [32:0] ipart;
        logic        inexact;
        logic        dsign;
    } s2_t;
endpackage

@@ src/fpdc_if.sv @@
interface fpdc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/fpdc_front.sv @@
module fpdc_front (
    input  fpdc_pkg::req_t  req,
    input  logic [5:0]      total_width,
    input  logic [5:0]      int_bits,
    output fpdc_pkg::s1_t   s1
);
    import fpdc_pkg::*;
    logic [5:0]  w;
    logic [5:0]  ib;
    logic [5:0]  f;
    logic [31:0] mask;
    logic [31:0] m;
    logic [31:0] sx;
    logic        neg;
    logic [10:0] ex;
    logic [51:0] fr;
    logic signed [12:0] e2;
    logic signed [12:0] sh;

    always_comb
    begin
        w = (total_width == 6'd0) ? 6'd1 : (total_width > 6'd32 ? 6'd32 : total_width);
        ib = (int_bits > w) ? w : int_bits;
        f = w - ib;
        mask = (w == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w[4:0]) - 32'd1);
        m = req.fixed_in & mask;
        neg = m[w[4:0] - 5'd1];
        sx = neg ? (m | ~mask) : m;
        s1 = '0;
        s1.func = req.func;
        s1.sign = sx[31];
        s1.mag = sx[31] ? (~sx + 32'd1) : sx;
        s1.frac = f;
        ex = req.double_in[62:52];
        fr = req.double_in[51:0];
        s1.dsign = req.double_in[63];
        s1.mant = {(ex != 11'd0), fr};
        // value*2^f = mant * 2^(e2); e2 = ex-1075+f (denormal ex acts as 1)
        e2 = $signed({2'b00, (ex == 11'd0) ? 11'd1 : ex}) - 13'sd1075
             + $signed({7'd0, f});
        sh = -e2;
        // a shift of 63 already leaves no integer bits but keeps every mantissa bit
        s1.rsh = (sh > 13'sd63) ? 7'd63 : (sh < 13'sd0 ? 7'd0 : sh[6:0]);
        if (ex == 11'h7FF && fr != 52'd0) begin
            s1.zero_out = 1'b1;
        end else if (ex == 11'h7FF || e2 > 13'sd0) begin
            // |x|*2^f >= 2^53 > 2^31, or infinity
            s1.sat = 1'b1;
        end else if (ex == 11'd0 && fr == 52'd0) begin
            s1.zero_out = 1'b1;
        end
        s1.sat_val = req.double_in[63] ? FIX_MIN : FIX_MAX;
    end
endmodule

@@ src/fpdc_mid.sv @@
module fpdc_mid (
    input  fpdc_pkg::s1_t s1,
    output fpdc_pkg::s2_t s2
);
    import fpdc_pkg::*;
    logic [115:0] ext;
    logic [115:0] shd;
    logic [5:0]   lz;
    logic         found;

    always_comb
    begin
        s2 = '0;
        s2.func = s1.func;
        s2.sign = s1.sign;
        s2.frac = s1.frac;
        lz = 6'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && s1.mag[i]) begin
                found = 1'b1;
                lz = 6'(31 - i);
            end
        end
        s2.lz = lz;
        s2.mzero = !found;
        s2.norm = s1.mag << lz;
        s2.zero_out = s1.zero_out;
        s2.sat = s1.sat;
        s2.sat_val = s1.sat_val;
        s2.dsign = s1.dsign;
        ext = {s1.mant, 63'd0};
        shd = ext >> s1.rsh;
        // shd[115:63] integer part, [62:0] fraction bits (only feed inexact)
        s2.ipart = (shd[115:96] != 20'd0) ? {1'b1, 32'd0} : shd[95:63];
        s2.inexact = (shd[62:0] != 63'd0);
    end
endmodule

@@ src/fpdc_back.sv @@
module fpdc_back (
    input  fpdc_pkg::s2_t  s2,
    output fpdc_pkg::rsp_t rsp
);
    import fpdc_pkg::*;
    logic [32:0] up;
    logic [10:0] ex;

    always_comb
    begin
        rsp = '0;
        up = '0;
        if (s2.func == FUNC_FIX2DBL) begin
            ex = 11'(12'd1023 + 12'd31 - {6'd0, s2.lz} - {6'd0, s2.frac});
            if (!s2.mzero) begin
                rsp.double_out = {s2.sign, ex, s2.norm[30:0], 21'd0};
            end
        end else begin
            ex = 11'd0;
            up = s2.ipart + {32'd0, s2.inexact};
            if (s2.zero_out) begin
                rsp.fixed_out = 32'd0;
            end else if (s2.sat) begin
                rsp.fixed_out = s2.sat_val;
                rsp.saturated = 1'b1;
            end else if (!s2.dsign) begin
                if (s2.ipart > 33'h0_7FFF_FFFF) begin
                    rsp.fixed_out = FIX_MAX;
                    rsp.saturated = 1'b1;
                end else begin
                    rsp.fixed_out = s2.ipart[31:0];
                end
            end else begin
                if (up > 33'h0_8000_0000) begin
                    rsp.fixed_out = FIX_MIN;
                    rsp.saturated = 1'b1;
                end else begin
                    rsp.fixed_out = ~up[31:0] + 32'd1;
                end
            end
        end
    end
endmodule

@@ src/fixed_point_double_converter.sv @@
// fixed_point_double_converter
// Converts signed fixed-point numbers to IEEE-754 doubles (func 0) and
// doubles to 32-bit fixed point with floor and saturation (func 1).
// Channels: req (sink) carries func, fixed_in, double_in; rsp (source)
// carries double_out, fixed_out, saturated. One response per request.
// Config: cfg_we/cfg_idx/cfg_data write total_width (0) and int_bits (1);
// write only while idle.
// Pipeline: three register stages (decode/align, leading-zero count and shift,
// pack/round) lie between request accept and response valid; throughput one
// request per cycle while the pipeline advances (rsp.ready high or output empty).
// Reset: pipeline emptied, total_width = 32, int_bits = 16.
// Stall: when rsp.ready is low and the output stage is full the whole pipeline
// holds; req.ready follows rsp.ready or an empty output stage, so nothing is lost or repeated.
`include "fixed_point_double_converter_assert.svh"
module fixed_point_double_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fpdc_pkg::CfgIdxW-1:0]  cfg_idx,
    input  logic [fpdc_pkg::CfgDataW-1:0] cfg_data,
    fpdc_if.sink                          req,
    fpdc_if.source                        rsp
);
    import fpdc_pkg::*;
    logic [5:0] tw_reg;
    logic [5:0] ib_reg;
    logic       v1_reg, v2_reg, v3_reg;
    s1_t        s1_next, s1_reg;
    s2_t        s2_next, s2_reg;
    rsp_t       r_next, r_reg;
    logic       adv;

    assign adv = rsp.ready || !v3_reg;
    assign req.ready = adv;
    assign rsp.valid = v3_reg;
    assign rsp.data = r_reg;

    fpdc_front u_front (.req(req.data), .total_width(tw_reg), .int_bits(ib_reg),
                        .s1(s1_next));
    fpdc_mid u_mid (.s1(s1_reg), .s2(s2_next));
    fpdc_back u_back (.s2(s2_reg), .rsp(r_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tw_reg <= 6'd32;
            ib_reg <= 6'd16;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_idx == REG_TOTAL_WIDTH) tw_reg <= cfg_data;
            if (cfg_we && cfg_idx == REG_INT_BITS) ib_reg <= cfg_data;
            if (adv) begin
                v1_reg <= req.valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            r_reg <= r_next;
        end
    end

    `FPDC_ASSERT_IMP(a_hold, rsp.valid && !rsp.ready, ##1 rsp.valid && $stable(r_reg),
        "response changed while stalled")
    `FPDC_ASSERT_IMP(a_sat_func, rsp.valid && r_reg.saturated,
        r_reg.double_out == 64'd0, "saturation on fixed-to-double")
    `FPDC_ASSERT_IMP(a_flow, req.valid && req.ready, ##1 v1_reg, "request lost")
endmodule
